[rtl/core/lse_pkg.sv]
// Shared types and codes for the LIFO stack engine.
package lse_pkg;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_PEEK  = 2'd2;
    localparam logic [1:0] MODE_DRAIN = 2'd3;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;
    localparam logic [1:0] ERR_INDEX = 2'd3;

    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_PUSH       = 3'd1;
    localparam logic [2:0] OP_POP        = 3'd2;
    localparam logic [2:0] OP_PEEK       = 3'd3;
    localparam logic [2:0] OP_FAULT      = 3'd4;
    localparam logic [2:0] OP_DRAIN_STEP = 3'd5;
    localparam logic [2:0] OP_DRAIN_END  = 3'd6;

    localparam int WORD_W = 32;
    localparam int POS_W  = 5;
    localparam int IDX_W  = 6;
    localparam int SUM_W  = 37;
    localparam int ACC_W  = 39;

    localparam logic signed [ACC_W-1:0] SUM_MAX = 39'sd68719476735;
    localparam logic signed [ACC_W-1:0] SUM_MIN = -39'sd68719476736;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] err;
        logic       acc_clr;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic peek_ok;
    } dp_status_t;

endpackage

[rtl/core/lse_ctrl.sv]
// Controller state machine: decodes requests and sequences drains.
module lse_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          mode,
    input  lse_pkg::dp_status_t status,
    output lse_pkg::dp_cmd_t    cmd,
    output logic                busy
);
    import lse_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ST_DRAIN);

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = OP_NONE;
        cmd.err     = ERR_OK;
        cmd.acc_clr = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        MODE_PUSH:
                        begin
                            if (status.full)
                            begin
                                cmd.op  = OP_FAULT;
                                cmd.err = ERR_FULL;
                            end
                            else
                            begin
                                cmd.op = OP_PUSH;
                            end
                        end
                        MODE_POP:
                        begin
                            if (status.empty)
                            begin
                                cmd.op  = OP_FAULT;
                                cmd.err = ERR_EMPTY;
                            end
                            else
                            begin
                                cmd.op = OP_POP;
                            end
                        end
                        MODE_PEEK:
                        begin
                            priority if (status.empty)
                            begin
                                cmd.op  = OP_FAULT;
                                cmd.err = ERR_EMPTY;
                            end
                            else if (!status.peek_ok)
                            begin
                                cmd.op  = OP_FAULT;
                                cmd.err = ERR_INDEX;
                            end
                            else
                            begin
                                cmd.op = OP_PEEK;
                            end
                        end
                        MODE_DRAIN:
                        begin
                            cmd.acc_clr = 1'b1;
                            if (status.empty)
                            begin
                                cmd.op = OP_DRAIN_END;
                            end
                            else
                            begin
                                cmd.op     = OP_DRAIN_STEP;
                                state_next = ST_DRAIN;
                            end
                        end
                        default:
                        begin
                            cmd.op = OP_NONE;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (status.empty)
                begin
                    cmd.op     = OP_DRAIN_END;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op = OP_DRAIN_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/lse_datapath.sv]
// Datapath: entry memory, entry count, drain accumulator and result registers.
module lse_datapath #(
    parameter int DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lse_pkg::dp_cmd_t                    cmd,
    input  logic signed [lse_pkg::WORD_W-1:0]   push_value,
    input  logic [lse_pkg::IDX_W-1:0]           depth_from_top,
    output lse_pkg::dp_status_t                 status,
    output logic                                strobe,
    output logic signed [lse_pkg::WORD_W-1:0]   data_word,
    output logic [lse_pkg::POS_W-1:0]           position,
    output logic signed [lse_pkg::SUM_W-1:0]    drain_sum,
    output logic                                is_empty,
    output logic                                is_full,
    output logic [1:0]                          error_code,
    output logic                                last
);
    import lse_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;

    logic signed [WORD_W-1:0] mem [DEPTH];

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [WORD_W-1:0] rd_data_reg;
    logic                     strobe_reg;
    logic                     sel_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     empty_reg;
    logic                     full_reg;
    logic [1:0]               err_reg;
    logic                     last_reg;

    logic [CW-1:0]            count_m1;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         d_ext;
    logic [CMP_W-1:0]         peek_diff;
    logic [AW-1:0]            rd_addr;
    logic                     rd_en;
    logic                     wr_en;
    logic [31:0]              addr_wide;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  sum_sat;

    assign count_m1  = count_reg - 1'b1;
    assign cnt_ext   = CMP_W'(count_reg);
    assign d_ext     = CMP_W'(depth_from_top);
    assign peek_diff = cnt_ext - d_ext;

    assign status.empty   = (count_reg == '0);
    assign status.full    = (count_reg == CW'(DEPTH));
    assign status.peek_ok = (d_ext != '0) && (d_ext <= cnt_ext);

    assign wr_en   = (cmd.op == OP_PUSH);
    assign rd_en   = (cmd.op == OP_POP) || (cmd.op == OP_PEEK) || (cmd.op == OP_DRAIN_STEP);
    assign rd_addr = (cmd.op == OP_PEEK) ? peek_diff[AW-1:0] : count_m1[AW-1:0];
    assign addr_wide = 32'(rd_addr);

    assign acc_sum = cmd.acc_clr ? '0 : (acc_reg + ACC_W'(rd_data_reg));

    always_comb
    begin
        priority if (acc_sum > SUM_MAX)
        begin
            sum_sat = SUM_MAX;
        end
        else if (acc_sum < SUM_MIN)
        begin
            sum_sat = SUM_MIN;
        end
        else
        begin
            sum_sat = acc_sum;
        end
    end

    always_comb
    begin
        unique case (cmd.op)
            OP_PUSH:       count_next = count_reg + 1'b1;
            OP_POP:        count_next = count_m1;
            OP_DRAIN_STEP: count_next = count_m1;
            default:       count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= (cmd.op != OP_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DRAIN_STEP)
        begin
            acc_reg <= acc_sum;
        end
        if (cmd.op != OP_NONE)
        begin
            sel_reg   <= rd_en;
            pos_reg   <= rd_en ? addr_wide[POS_W-1:0] : '0;
            sum_reg   <= (cmd.op == OP_DRAIN_END) ? sum_sat[SUM_W-1:0] : '0;
            empty_reg <= (count_next == '0);
            full_reg  <= (count_next == CW'(DEPTH));
            err_reg   <= (cmd.op == OP_FAULT) ? cmd.err : ERR_OK;
            last_reg  <= (cmd.op != OP_DRAIN_STEP);
        end
    end

    assign strobe     = strobe_reg;
    assign data_word  = sel_reg ? rd_data_reg : '0;
    assign position   = pos_reg;
    assign drain_sum  = sum_reg;
    assign is_empty   = empty_reg;
    assign is_full    = full_reg;
    assign error_code = err_reg;
    assign last       = last_reg;

endmodule

[rtl/core/lifo_stack_engine_core.sv]
// Top level of the LIFO stack engine: controller plus datapath.
// A request is taken when start is high and busy is low. For push, pop and peek
// the result strobe rises in the cycle after the request and a new request may
// be issued in that same cycle. A drain of N entries keeps busy high while it
// steps through them and gives N + 1 results on consecutive cycles, one per
// entry from the top down and then the final beat with the sum; the single-port
// entry memory is read once per cycle during a drain. Every beat is on the
// result ports for one cycle only and cannot be held off, so the receiver must
// take each strobe as it comes. Failed requests report an error code and leave
// the stack unchanged.
module lifo_stack_engine_core #(
    parameter int DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          mode,
    input  logic signed [lse_pkg::WORD_W-1:0]   push_value,
    input  logic [lse_pkg::IDX_W-1:0]           depth_from_top,
    output logic                                strobe,
    output logic signed [lse_pkg::WORD_W-1:0]   data_word,
    output logic [lse_pkg::POS_W-1:0]           position,
    output logic signed [lse_pkg::SUM_W-1:0]    drain_sum,
    output logic                                is_empty,
    output logic                                is_full,
    output logic [1:0]                          error_code,
    output logic                                last
);
    import lse_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    lse_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lse_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .push_value     (push_value),
        .depth_from_top (depth_from_top),
        .status         (status),
        .strobe         (strobe),
        .data_word      (data_word),
        .position       (position),
        .drain_sum      (drain_sum),
        .is_empty       (is_empty),
        .is_full        (is_full),
        .error_code     (error_code),
        .last           (last)
    );

    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> strobe)
        else $error("accepted request produced no result beat");

    a_entry_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("drain entry beat while not busy");

    a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (error_code != ERR_OK) |-> (data_word == '0) && (drain_sum == '0) && last)
        else $error("error beat carries payload");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !(is_empty && is_full))
        else $error("empty and full both set");

endmodule

[tb/lifo_stack_engine_core_tb.sv]
// Self-checking testbench for the LIFO stack engine core: stimulus, prediction and checking.
`timescale 1ns / 100ps

module lifo_stack_engine_core_tb;

    import lse_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 110;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
        logic [5:0]  depth;
    } stack_op_t;

    typedef struct packed {
        logic signed [31:0] data_word;
        logic [4:0]         position;
        logic signed [36:0] drain_sum;
        logic               is_empty;
        logic               is_full;
        logic [1:0]         error_code;
        logic               last;
    } stack_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         mode = MODE_PUSH;
    logic signed [31:0] push_value = '0;
    logic [5:0]         depth_from_top = '0;
    logic               busy;
    logic               strobe;
    logic signed [31:0] data_word;
    logic [4:0]         position;
    logic signed [36:0] drain_sum;
    logic               is_empty;
    logic               is_full;
    logic [1:0]         error_code;
    logic               last;

    stack_op_t          op_q[$];
    stack_beat_t        beat_q[$];
    logic signed [31:0] shadow_store[STACK_DEPTH];
    int                 shadow_count = 0;
    int                 gen_count = 0;
    int                 phase_items = 0;
    int                 idle_pct = 0;
    int                 mismatch_count = 0;
    int                 stall_cycles = 0;

    lifo_stack_engine_core #(
        .DEPTH(STACK_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .push_value(push_value),
        .depth_from_top(depth_from_top),
        .strobe(strobe),
        .data_word(data_word),
        .position(position),
        .drain_sum(drain_sum),
        .is_empty(is_empty),
        .is_full(is_full),
        .error_code(error_code),
        .last(last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic apply_stack_op(input logic [1:0] op_mode, input logic signed [31:0] value,
                                  input logic [5:0] d);
        stack_beat_t b;
        longint      total;
        int          slot;
        b = '0;
        total = 0;
        case (op_mode)
            MODE_PUSH:
            begin
                if (shadow_count == STACK_DEPTH)
                    b.error_code = ERR_FULL;
                else
                begin
                    shadow_store[shadow_count] = value;
                    shadow_count++;
                end
            end
            MODE_POP:
            begin
                if (shadow_count == 0)
                    b.error_code = ERR_EMPTY;
                else
                begin
                    shadow_count--;
                    b.data_word = shadow_store[shadow_count];
                    b.position = shadow_count[4:0];
                end
            end
            MODE_PEEK:
            begin
                if (shadow_count == 0)
                    b.error_code = ERR_EMPTY;
                else if (d == 0 || int'(d) > shadow_count)
                    b.error_code = ERR_INDEX;
                else
                begin
                    slot = shadow_count - int'(d);
                    b.data_word = shadow_store[slot];
                    b.position = slot[4:0];
                end
            end
            default:
            begin
                while (shadow_count > 0)
                begin
                    shadow_count--;
                    total += shadow_store[shadow_count];
                    b.data_word = shadow_store[shadow_count];
                    b.position = shadow_count[4:0];
                    b.is_empty = (shadow_count == 0);
                    b.is_full = 1'b0;
                    b.last = 1'b0;
                    beat_q.push_back(b);
                end
                b = '0;
                b.drain_sum = total[36:0];
            end
        endcase
        b.is_empty = (shadow_count == 0);
        b.is_full = (shadow_count == STACK_DEPTH);
        b.last = 1'b1;
        beat_q.push_back(b);
    endtask

    task automatic queue_op(input logic [1:0] op_mode, input logic [31:0] value,
                            input logic [5:0] d);
        stack_op_t item;
        item.mode = op_mode;
        item.value = value;
        item.depth = d;
        op_q.push_back(item);
        phase_items++;
        if (op_mode == MODE_PUSH && gen_count < STACK_DEPTH)
            gen_count++;
        else if (op_mode == MODE_POP && gen_count > 0)
            gen_count--;
        else if (op_mode == MODE_DRAIN)
            gen_count = 0;
    endtask

    // fill up with max, min or random values, overrun, probe the bottom, then maybe drain
    task automatic fill_burst(input int kind, input bit do_drain);
        logic [31:0] v;
        while (gen_count < STACK_DEPTH)
        begin
            if (kind == 0)
                v = 32'h7FFF_FFFF;
            else if (kind == 1)
                v = 32'h8000_0000;
            else
                v = $urandom;
            queue_op(MODE_PUSH, v, 6'($urandom));
        end
        queue_op(MODE_PUSH, $urandom, 6'($urandom));
        queue_op(MODE_PEEK, $urandom, 6'd32);
        queue_op(MODE_PEEK, $urandom, 6'd33);
        if (do_drain)
            queue_op(MODE_DRAIN, $urandom, 6'($urandom));
    endtask

    task automatic queue_random_op();
        int          r;
        int          sel;
        logic [31:0] v;
        logic [5:0]  d;
        r = $urandom_range(99);
        if (r < 3)
            fill_burst(int'($urandom_range(2)), 1'($urandom_range(1)));
        else if (r < 48)
        begin
            sel = $urandom_range(9);
            if (sel == 0)
                v = 32'h7FFF_FFFF;
            else if (sel == 1)
                v = 32'h8000_0000;
            else
                v = $urandom;
            queue_op(MODE_PUSH, v, 6'($urandom));
        end
        else if (r < 68)
            queue_op(MODE_POP, $urandom, 6'($urandom));
        else if (r < 92)
        begin
            sel = $urandom_range(9);
            if (sel < 7)
                d = (gen_count > 0) ? 6'($urandom_range(gen_count, 1)) : 6'd1;
            else if (sel == 7)
                d = 6'd0;
            else if (sel == 8)
                d = 6'(gen_count + 1);
            else
                d = 6'($urandom_range(63));
            queue_op(MODE_PEEK, $urandom, d);
        end
        else
            queue_op(MODE_DRAIN, $urandom, 6'($urandom));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        stack_op_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
            mode <= MODE_PUSH;
            push_value <= '0;
            depth_from_top <= '0;
        end
        else
        begin
            if (start && !busy)
                apply_stack_op(mode, push_value, depth_from_top);
            // hold the request until the block takes it
            if (!(start && busy))
            begin
                if (op_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = op_q.pop_front();
                    start <= 1'b1;
                    mode <= nxt.mode;
                    push_value <= nxt.value;
                    depth_from_top <= nxt.depth;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string tag, input stack_beat_t got,
                                   input stack_beat_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: got data=%0d pos=%0d sum=%0d e=%b f=%b err=%0d last=%b,",
                     $realtime, tag, got.data_word, got.position, got.drain_sum, got.is_empty,
                     got.is_full, got.error_code, got.last,
                     " expected data=%0d pos=%0d sum=%0d e=%b f=%b err=%0d last=%b",
                     want.data_word, want.position, want.drain_sum, want.is_empty,
                     want.is_full, want.error_code, want.last);
    endtask

    always @(posedge clk)
    begin : observe
        stack_beat_t got;
        stack_beat_t want;
        if (rst_n && strobe)
        begin
            got = '{data_word, position, drain_sum, is_empty, is_full, error_code, last};
            if (beat_q.size() == 0)
                report_mismatch("unexpected beat", got, '0);
            else
            begin
                want = beat_q.pop_front();
                if (got !== want)
                    report_mismatch("beat mismatch", got, want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_op(MODE_POP, 32'h0, 6'd0);
        queue_op(MODE_PEEK, 32'h0, 6'd1);
        queue_op(MODE_DRAIN, 32'h0, 6'd0);
        queue_op(MODE_PUSH, 32'h7FFF_FFFF, 6'd0);
        queue_op(MODE_PUSH, 32'h8000_0000, 6'd63);
        queue_op(MODE_PUSH, 32'hFFFF_FFFF, 6'd0);
        queue_op(MODE_PUSH, 32'h0000_0000, 6'd0);
        queue_op(MODE_PEEK, 32'h0, 6'd0);
        queue_op(MODE_PEEK, 32'h0, 6'd1);
        queue_op(MODE_PEEK, 32'h0, 6'd4);
        queue_op(MODE_PEEK, 32'h0, 6'd5);
        queue_op(MODE_PEEK, 32'h0, 6'd63);
        queue_op(MODE_POP, 32'h0, 6'd0);
        queue_op(MODE_DRAIN, 32'h0, 6'd0);
        queue_op(MODE_PUSH, 32'h5, 6'd0);
        queue_op(MODE_PUSH, 32'h6, 6'd0);
        queue_op(MODE_DRAIN, 32'h0, 6'd0);

        for (phase = 0; phase < 3; phase++)
        begin
            // let every pending beat come back before the next phase
            while (op_q.size() != 0 || start || beat_q.size() != 0)
                @(negedge clk);
            idle_pct = (phase == 0) ? 0 : (phase == 1) ? 54 : 21;
            phase_items = 0;
            fill_burst(phase, 1'b1);
            while (phase_items < PHASE_ITEMS)
                queue_random_op();
        end

        while (op_q.size() != 0 || start || beat_q.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && beat_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
